@@ rtl/core/pes_pkg.sv @@
// pes_pkg: shared constants and register codes for the plane edge slicer
// no dependencies; compile first
package pes_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int AXIS_BITS      = 16;
    localparam int AXIS_FRAC      = 14;
    localparam int CFG_DATA_BITS  = 48;
    localparam int CFG_IDX_BITS   = 3;
    localparam int MUL_DIGIT      = 16;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_NORMAL   = 3'd0,
        REG_AXIS_X   = 3'd1,
        REG_AXIS_Y   = 3'd2,
        REG_TARGET_X = 3'd3,
        REG_TARGET_Y = 3'd4,
        REG_TARGET_Z = 3'd5
    } cfg_reg_t;

    localparam logic [CFG_DATA_BITS-1:0] NORMAL_RST = 48'h4000_0000_0000;
    localparam logic [CFG_DATA_BITS-1:0] AXIS_X_RST = 48'h0000_0000_4000;
    localparam logic [CFG_DATA_BITS-1:0] AXIS_Y_RST = 48'h0000_4000_0000;

endpackage

@@ rtl/core/pes_if.sv @@
// pes_if: valid/ready channels for edge words in and slice words out
// depends on pes_pkg
interface pes_edge_if
    import pes_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] start_z;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] end_z;

    modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                    input ready);
    modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  output ready);
endinterface

interface pes_slice_if
    import pes_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
();
    logic                         valid;
    logic                         ready;
    logic                         crosses;
    logic                         start_on_plane;
    logic                         degenerate;
    logic signed [COORD_BITS-1:0] hit_x;
    logic signed [COORD_BITS-1:0] hit_y;
    logic signed [COORD_BITS-1:0] hit_z;
    logic signed [COORD_BITS-1:0] plane_u;
    logic signed [COORD_BITS-1:0] plane_v;

    modport source (output valid, crosses, start_on_plane, degenerate, hit_x, hit_y, hit_z,
                    plane_u, plane_v, input ready);
    modport sink (input valid, crosses, start_on_plane, degenerate, hit_x, hit_y, hit_z,
                  plane_u, plane_v, output ready);
endinterface

@@ rtl/core/pes_quot.sv @@
// pes_quot: pipelined magnitude quotient (num * u) / den, one quotient bit per stage
// depends on pes_pkg; all registers advance only while en is high
module pes_quot
    import pes_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      en,
    input  logic [COORD_BITS+19:0]    num_mag,
    input  logic [COORD_BITS+19:0]    den_mag,
    input  logic [COORD_BITS-1:0]     u_mag,
    output logic [COORD_BITS-1:0]     q_mag
);

    localparam int C   = COORD_BITS;
    localparam int NW  = C + 20;
    localparam int ND  = (C + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int BW  = ND * MUL_DIGIT;
    localparam int PPW = NW + MUL_DIGIT;
    localparam int PMW = NW + C;

    logic [BW-1:0]  b_pad;
    logic [PPW-1:0] pp_reg [ND];
    logic [NW-1:0]  d1_reg;
    logic [PMW-1:0] acc_next;
    logic [PMW-1:0] acc_reg;
    logic [NW-1:0]  d2_reg;

    logic [NW-1:0]  r_reg  [C-1];
    logic [NW-1:0]  dv_reg [C-1];
    logic [C-1:0]   lq_reg [C];

    assign b_pad = BW'(u_mag);

    // partial products, one digit of u each
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < ND; j++)
            begin
                pp_reg[j] <= PPW'(num_mag) * PPW'(b_pad[j*MUL_DIGIT +: MUL_DIGIT]);
            end
            d1_reg <= den_mag;
        end
    end

    always_comb
    begin
        acc_next = '0;
        for (int j = 0; j < ND; j++)
        begin
            acc_next = acc_next + (PMW'(pp_reg[j]) << (j * MUL_DIGIT));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc_reg <= acc_next;
            d2_reg  <= d1_reg;
        end
    end

    // restoring division, quotient bits shift in behind the dividend bits
    for (genvar i = 0; i < C; i++)
    begin : g_div
        logic [NW-1:0] r_in;
        logic [NW-1:0] d_in;
        logic [C-1:0]  lq_in;
        logic [NW:0]   r2;
        logic [NW:0]   diff;
        logic          ge;

        if (i == 0)
        begin : g_first
            assign r_in  = acc_reg[PMW-1:C];
            assign lq_in = acc_reg[C-1:0];
            assign d_in  = d2_reg;
        end
        else
        begin : g_next
            assign r_in  = r_reg[i-1];
            assign lq_in = lq_reg[i-1];
            assign d_in  = dv_reg[i-1];
        end

        assign r2   = {r_in, lq_in[C-1]};
        assign ge   = r2 >= {1'b0, d_in};
        assign diff = r2 - {1'b0, d_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lq_reg[i] <= {lq_in[C-2:0], ge};
            end
        end

        if (i < C - 1)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[i]  <= ge ? diff[NW-1:0] : r2[NW-1:0];
                    dv_reg[i] <= d_in;
                end
            end
        end
    end

    assign q_mag = lq_reg[C-1];

endmodule

@@ rtl/core/plane_edge_slicer.sv @@
// plane_edge_slicer: intersects streamed mesh edges with a configured plane
// depends on pes_pkg, pes_if and pes_quot
//
// One edge word is accepted per cycle while the skid stage is empty. A slice word passes
// through the quotient pipeline, which resolves one quotient bit per stage in three
// parallel lanes, plus the six arithmetic stages after the first one (loaded at the
// accepting edge) and the output register. A skid stage behind the pipeline takes the
// next result when the consumer stalls; once it is full, the whole pipeline holds.
// Configuration must only be written while no edge is in flight.
module plane_edge_slicer
    import pes_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    pes_edge_if.sink                 edge_in,
    pes_slice_if.source              slice_out
);

    localparam int C    = COORD_BITS;
    localparam int DSW  = C + 1;
    localparam int PW   = C + 17;
    localparam int DW   = C + 19;
    localparam int NW   = C + 20;
    localparam int LAT  = C + 2;
    localparam int HW   = C + 2;
    localparam int RW   = C + 3;
    localparam int QPW  = C + 19;
    localparam int PUW  = C + 22;
    localparam int SATW = PUW - AXIS_FRAC;
    localparam logic signed [PUW-1:0] HALF = PUW'(2 ** (AXIS_FRAC - 1));

    typedef struct packed {
        logic              crosses;
        logic              sop;
        logic              deg;
        logic [2:0]        neg;
        logic [2:0][C-1:0] s;
    } side_t;

    typedef struct packed {
        logic         crosses;
        logic         sop;
        logic         deg;
        logic [C-1:0] hit_x;
        logic [C-1:0] hit_y;
        logic [C-1:0] hit_z;
        logic [C-1:0] pu;
        logic [C-1:0] pv;
    } res_t;

    function automatic logic [C-1:0] sat(input logic signed [SATW-1:0] v);
        logic [SATW-C:0] upper;
        upper = v[SATW-1:C-1];
        if ((&upper) || !(|upper))
            sat = v[C-1:0];
        else if (v[SATW-1])
            sat = {1'b1, {(C-1){1'b0}}};
        else
            sat = {1'b0, {(C-1){1'b1}}};
    endfunction

    // configuration
    logic [CFG_DATA_BITS-1:0] normal_reg;
    logic [CFG_DATA_BITS-1:0] axis_x_reg;
    logic [CFG_DATA_BITS-1:0] axis_y_reg;
    logic signed [C-1:0]      tx_reg;
    logic signed [C-1:0]      ty_reg;
    logic signed [C-1:0]      tz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_reg <= NORMAL_RST;
            axis_x_reg <= AXIS_X_RST;
            axis_y_reg <= AXIS_Y_RST;
            tx_reg     <= '0;
            ty_reg     <= '0;
            tz_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_NORMAL:   normal_reg <= cfg_data;
                REG_AXIS_X:   axis_x_reg <= cfg_data;
                REG_AXIS_Y:   axis_y_reg <= cfg_data;
                REG_TARGET_X: tx_reg     <= cfg_data[C-1:0];
                REG_TARGET_Y: ty_reg     <= cfg_data[C-1:0];
                REG_TARGET_Z: tz_reg     <= cfg_data[C-1:0];
                default:      ;
            endcase
        end
    end

    logic signed [C-1:0]         t   [3];
    logic signed [AXIS_BITS-1:0] nv  [3];
    logic signed [AXIS_BITS-1:0] axv [3];
    logic signed [AXIS_BITS-1:0] ayv [3];
    logic signed [C-1:0]         s_in [3];
    logic signed [C-1:0]         e_in [3];

    always_comb
    begin
        t[0] = tx_reg;
        t[1] = ty_reg;
        t[2] = tz_reg;
        for (int k = 0; k < 3; k++)
        begin
            nv[k]  = normal_reg[k*AXIS_BITS +: AXIS_BITS];
            axv[k] = axis_x_reg[k*AXIS_BITS +: AXIS_BITS];
            ayv[k] = axis_y_reg[k*AXIS_BITS +: AXIS_BITS];
        end
        s_in[0] = edge_in.start_x;
        s_in[1] = edge_in.start_y;
        s_in[2] = edge_in.start_z;
        e_in[0] = edge_in.end_x;
        e_in[1] = edge_in.end_y;
        e_in[2] = edge_in.end_z;
    end

    // pipeline advance
    logic en;
    logic skid_valid_reg;

    assign en            = !skid_valid_reg;
    assign edge_in.ready = en;

    // stage registers
    logic                  a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic                  e_valid_reg, f_valid_reg, g_valid_reg;
    logic                  sv_reg [LAT];

    logic signed [DSW-1:0] a_ds_reg [3];
    logic signed [DSW-1:0] a_de_reg [3];
    logic signed [DSW-1:0] a_u_reg  [3];
    logic signed [C-1:0]   a_s_reg  [3];

    logic signed [PW-1:0]  b_p0_reg [3];
    logic signed [PW-1:0]  b_p1_reg [3];
    logic signed [DSW-1:0] b_u_reg  [3];
    logic signed [C-1:0]   b_s_reg  [3];

    logic signed [DW-1:0]  c_d0_reg;
    logic signed [DW-1:0]  c_d1_reg;
    logic signed [DSW-1:0] c_u_reg  [3];
    logic signed [C-1:0]   c_s_reg  [3];

    logic signed [NW-1:0]  den;
    logic signed [NW-1:0]  num;
    logic signed [DSW-1:0] u_neg    [3];
    logic [C-1:0]          u_mag    [3];
    side_t                 d_side;

    logic [NW-1:0]         d_num_reg;
    logic [NW-1:0]         d_den_reg;
    logic [C-1:0]          d_umag_reg [3];
    side_t                 d_side_reg;
    side_t                 side_reg [LAT];

    logic [C-1:0]          qm  [3];
    logic signed [C:0]     qs  [3];
    logic signed [HW-1:0]  h   [3];

    logic [C-1:0]          e_hit_reg [3];
    logic signed [RW-1:0]  e_rel_reg [3];
    logic [2:0]            e_flag_reg;

    logic signed [QPW-1:0] f_pu_reg [3];
    logic signed [QPW-1:0] f_pv_reg [3];
    logic [C-1:0]          f_hit_reg [3];
    logic [2:0]            f_flag_reg;

    logic signed [PUW-1:0] pu_sum;
    logic signed [PUW-1:0] pv_sum;
    res_t                  g_res;
    res_t                  g_res_reg;

    res_t                  out_reg;
    res_t                  skid_reg;
    logic                  out_valid_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            for (int i = 0; i < LAT; i++)
            begin
                sv_reg[i] <= 1'b0;
            end
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= edge_in.valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            sv_reg[0]   <= d_valid_reg;
            for (int i = 1; i < LAT; i++)
            begin
                sv_reg[i] <= sv_reg[i-1];
            end
            e_valid_reg <= sv_reg[LAT-1];
            f_valid_reg <= e_valid_reg;
            g_valid_reg <= f_valid_reg;
        end
    end

    // signed distances
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                a_ds_reg[k] <= DSW'(s_in[k]) - DSW'(t[k]);
                a_de_reg[k] <= DSW'(e_in[k]) - DSW'(t[k]);
                a_u_reg[k]  <= DSW'(e_in[k]) - DSW'(s_in[k]);
                a_s_reg[k]  <= s_in[k];

                b_p0_reg[k] <= PW'(a_ds_reg[k]) * PW'(nv[k]);
                b_p1_reg[k] <= PW'(a_de_reg[k]) * PW'(nv[k]);
                b_u_reg[k]  <= a_u_reg[k];
                b_s_reg[k]  <= a_s_reg[k];

                c_u_reg[k]  <= b_u_reg[k];
                c_s_reg[k]  <= b_s_reg[k];
            end
            c_d0_reg <= DW'(b_p0_reg[0]) + DW'(b_p0_reg[1]) + DW'(b_p0_reg[2]);
            c_d1_reg <= DW'(b_p1_reg[0]) + DW'(b_p1_reg[1]) + DW'(b_p1_reg[2]);
        end
    end

    // crossing test and operand magnitudes
    always_comb
    begin
        den = NW'(c_d1_reg) - NW'(c_d0_reg);
        num = -(NW'(c_d0_reg));
        d_side.crosses = (c_d0_reg != '0) && (c_d1_reg != '0)
                         && (c_d0_reg[DW-1] != c_d1_reg[DW-1]);
        d_side.sop = (c_d0_reg == '0);
        d_side.deg = (den == '0);
        for (int k = 0; k < 3; k++)
        begin
            u_neg[k]      = -c_u_reg[k];
            u_mag[k]      = c_u_reg[k][C] ? u_neg[k][C-1:0] : c_u_reg[k][C-1:0];
            d_side.neg[k] = num[NW-1] ^ c_u_reg[k][C] ^ den[NW-1];
            d_side.s[k]   = c_s_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_num_reg <= num[NW-1] ? -num : num;
            d_den_reg <= den[NW-1] ? -den : den;
            for (int k = 0; k < 3; k++)
            begin
                d_umag_reg[k] <= u_mag[k];
            end
            d_side_reg <= d_side;
            side_reg[0] <= d_side_reg;
            for (int i = 1; i < LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        pes_quot #(
            .COORD_BITS (COORD_BITS)
        ) u_quot (
            .clk     (clk),
            .en      (en),
            .num_mag (d_num_reg),
            .den_mag (d_den_reg),
            .u_mag   (d_umag_reg[k]),
            .q_mag   (qm[k])
        );
    end

    // hit point, projection and rounding
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            qs[k] = side_reg[LAT-1].neg[k] ? -(signed'({1'b0, qm[k]}))
                                           : signed'({1'b0, qm[k]});
            h[k]  = HW'(signed'(side_reg[LAT-1].s[k])) + HW'(qs[k]);
        end
        pu_sum = PUW'(f_pu_reg[0]) + PUW'(f_pu_reg[1]) + PUW'(f_pu_reg[2]) + HALF;
        pv_sum = PUW'(f_pv_reg[0]) + PUW'(f_pv_reg[1]) + PUW'(f_pv_reg[2]) + HALF;
        g_res.crosses = f_flag_reg[2];
        g_res.sop     = f_flag_reg[1];
        g_res.deg     = f_flag_reg[0];
        g_res.hit_x   = f_flag_reg[2] ? f_hit_reg[0] : '0;
        g_res.hit_y   = f_flag_reg[2] ? f_hit_reg[1] : '0;
        g_res.hit_z   = f_flag_reg[2] ? f_hit_reg[2] : '0;
        g_res.pu      = f_flag_reg[2] ? sat(pu_sum[PUW-1:AXIS_FRAC]) : '0;
        g_res.pv      = f_flag_reg[2] ? sat(pv_sum[PUW-1:AXIS_FRAC]) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e_hit_reg[k] <= sat(SATW'(h[k]));
                e_rel_reg[k] <= RW'(h[k]) - RW'(t[k]);
                f_pu_reg[k]  <= QPW'(e_rel_reg[k]) * QPW'(axv[k]);
                f_pv_reg[k]  <= QPW'(e_rel_reg[k]) * QPW'(ayv[k]);
                f_hit_reg[k] <= e_hit_reg[k];
            end
            e_flag_reg <= {side_reg[LAT-1].crosses, side_reg[LAT-1].sop,
                           side_reg[LAT-1].deg};
            f_flag_reg <= e_flag_reg;
            g_res_reg  <= g_res;
        end
    end

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || slice_out.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= g_valid_reg;
            end
        end
        else if (g_valid_reg && !skid_valid_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || slice_out.ready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : g_res_reg;
        end
        else if (!skid_valid_reg)
        begin
            skid_reg <= g_res_reg;
        end
    end

    assign slice_out.valid          = out_valid_reg;
    assign slice_out.crosses        = out_reg.crosses;
    assign slice_out.start_on_plane = out_reg.sop;
    assign slice_out.degenerate     = out_reg.deg;
    assign slice_out.hit_x          = out_reg.hit_x;
    assign slice_out.hit_y          = out_reg.hit_y;
    assign slice_out.hit_z          = out_reg.hit_z;
    assign slice_out.plane_u        = out_reg.pu;
    assign slice_out.plane_v        = out_reg.pv;

endmodule
